// ===== hdl/row_kth_smallest_select_unit_assert.svh =====
// assertion macros for the row k-th smallest select unit
`ifndef ROW_KTH_SMALLEST_SELECT_UNIT_ASSERT_SVH
`define ROW_KTH_SMALLEST_SELECT_UNIT_ASSERT_SVH

// same-cycle implication
`define RKSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkss assertion failed");

// next-cycle implication
`define RKSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkss assertion failed");

`endif

// ===== hdl/rkss_pkg.sv =====
// package with shared types, constants and the ordering key function
`default_nettype none

package rkss_pkg;

    localparam int VAL_W      = 64;
    localparam int IDX_W      = 12;
    localparam int K_W        = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_K_RANK       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_FORMAT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

    localparam logic [VAL_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic               valid;
        logic               carry;
        logic               shifting;
        logic               fmt;
        logic               last;
        logic               over;
        logic [K_W-1:0]     sel;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   index;
        logic               ans_valid;
        logic [VAL_W-1:0]   ans_value;
        logic [IDX_W-1:0]   ans_index;
    } t_token;

    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v,
                                                    input logic fmt);
        logic [VAL_W-1:0] key;
        if (!fmt) begin
            key = v ^ SIGN_BIT;
        end else if ((&v[62:52]) && (|v[51:0])) begin
            key = '1;
        end else if (v[62:0] == '0) begin
            key = SIGN_BIT;
        end else if (v[63]) begin
            key = ~v;
        end else begin
            key = v | SIGN_BIT;
        end
        return key;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rkss_in_if.sv =====
// element input channel
`default_nettype none

interface rkss_in_if import rkss_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] elem_value;
    logic                    last_in_row;

    modport source (output valid, output elem_value, output last_in_row, input ready);
    modport sink (input valid, input elem_value, input last_in_row, output ready);
endinterface

`default_nettype wire

// ===== hdl/rkss_out_if.sv =====
// result output channel
`default_nettype none

interface rkss_out_if import rkss_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] kth_value;
    logic [IDX_W-1:0]        kth_index;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, output kth_value, output kth_index, output status,
                    input ready);
    modport sink (input valid, input kth_value, input kth_index, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/rkss_cell.sv =====
// one insertion cell: holds one kept element and passes the token on
`default_nettype none

module rkss_cell import rkss_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    localparam bit             SELECTABLE = (CELL_IDX < (1 << K_W));
    localparam logic [K_W-1:0] CELL_SEL   = K_W'(CELL_IDX);

    logic             r_valid;
    logic             n_valid;
    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [IDX_W-1:0] r_index;
    logic [IDX_W-1:0] n_index;
    t_token           r_tok;
    t_token           n_tok;
    logic             held_gt;

    assign held_gt = order_key(r_value, i_tok.fmt) > order_key(i_tok.value, i_tok.fmt);

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_value = r_value;
        n_index = r_index;
        if (i_tok.valid) begin
            if (i_tok.carry) begin
                if (!r_valid) begin
                    n_valid     = 1'b1;
                    n_value     = i_tok.value;
                    n_index     = i_tok.index;
                    n_tok.carry = 1'b0;
                end else if (i_tok.shifting || held_gt) begin
                    n_value        = i_tok.value;
                    n_index        = i_tok.index;
                    n_tok.value    = r_value;
                    n_tok.index    = r_index;
                    n_tok.shifting = 1'b1;
                end
            end
            if (SELECTABLE && i_tok.last && (i_tok.sel == CELL_SEL)) begin
                n_tok.ans_valid = n_valid;
                n_tok.ans_value = n_value;
                n_tok.ans_index = n_index;
            end
            // end of row empties the cell for the next row
            if (i_tok.last) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= n_value;
            r_index <= n_index;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== hdl/row_kth_smallest_select_unit.sv =====
// top level: row k-th smallest selection over a chain of insertion cells
// The unit accepts one row element per clock cycle whenever the result register is free or
// being taken; a result held off by the result side stalls the whole chain and the input.
// Each element travels down a chain of K_MAX insertion cells, one cell per cycle,
// and the cells keep the K_MAX smallest elements of the current row in ascending order with
// their positions. The result for a row passes through the K_MAX cell registers and then the
// result register, where it waits while the result side holds off; rows follow each other
// with no gap. k_rank of zero acts as one, and values above K_MAX act as K_MAX. Positions
// saturate at ROW_MAX - 1.
`default_nettype none
`include "row_kth_smallest_select_unit_assert.svh"

module row_kth_smallest_select_unit import rkss_pkg::*; #(
    parameter int ROW_MAX = 4096,
    parameter int K_MAX   = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rkss_in_if.sink                    i_elem,
    rkss_out_if.source                 o_result
);

    localparam int PW = $clog2(ROW_MAX + 1);

    logic [K_W-1:0]      r_k_rank;
    logic                r_fmt;
    logic [PW-1:0]       r_pos;
    logic                pos_over;
    logic [PW-1:0]       pos_idx;
    logic [K_W-1:0]      k_eff;
    logic [K_W-1:0]      sel;
    logic                adv;
    logic                in_accept;
    t_token              tok_head;
    t_token              tok [K_MAX+1];
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [IDX_W-1:0]    r_out_index;
    logic [STATUS_W-1:0] r_out_status;
    logic                row_end;
    logic                elem_step;
    logic                out_short;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_rank <= K_W'(1);
            r_fmt    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_K_RANK:       r_k_rank <= i_cfg_wdata;
                CFG_VALUE_FORMAT: r_fmt    <= i_cfg_wdata[0];
            endcase
        end
    end

    assign adv          = !r_out_valid || o_result.ready;
    assign i_elem.ready = adv;
    assign in_accept    = i_elem.valid && adv;

    // row position, saturating
    assign pos_over = (r_pos == PW'(ROW_MAX));
    assign pos_idx  = pos_over ? PW'(ROW_MAX - 1) : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_accept) begin
            if (i_elem.last_in_row) begin
                r_pos <= '0;
            end else if (!pos_over) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    // rank clamp
    always_comb begin
        k_eff = (r_k_rank == '0) ? K_W'(1) : r_k_rank;
        if (32'(k_eff) > K_MAX) begin
            sel = K_W'(K_MAX - 1);
        end else begin
            sel = k_eff - K_W'(1);
        end
    end

    always_comb begin
        tok_head          = '0;
        tok_head.valid    = i_elem.valid;
        tok_head.carry    = 1'b1;
        tok_head.shifting = 1'b0;
        tok_head.fmt      = r_fmt;
        tok_head.last     = i_elem.last_in_row;
        tok_head.over     = pos_over;
        tok_head.sel      = sel;
        tok_head.value    = $unsigned(i_elem.elem_value);
        tok_head.index    = IDX_W'(pos_idx);
    end

    assign tok[0] = tok_head;

    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        rkss_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_tok  (tok[g]),
            .o_tok  (tok[g+1])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tok[K_MAX].valid && tok[K_MAX].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (!tok[K_MAX].ans_valid) begin
                r_out_value  <= '0;
                r_out_index  <= '0;
                r_out_status <= ST_SHORT;
            end else begin
                r_out_value  <= tok[K_MAX].ans_value;
                r_out_index  <= tok[K_MAX].ans_index;
                r_out_status <= tok[K_MAX].over ? ST_LONG : ST_OK;
            end
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.kth_value = $signed(r_out_value);
    assign o_result.kth_index = r_out_index;
    assign o_result.status    = r_out_status;

    assign row_end   = in_accept && i_elem.last_in_row;
    assign elem_step = in_accept && !i_elem.last_in_row && !pos_over;
    assign out_short = r_out_valid && (r_out_status == ST_SHORT);

    `RKSS_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= PW'(ROW_MAX))
    `RKSS_ASSERT_NEXT(a_pos_row_restart, i_clk, i_rst_n, row_end, r_pos == '0)
    `RKSS_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, elem_step, r_pos == PW'($past(r_pos) + PW'(1)))
    `RKSS_ASSERT_NOW(a_short_zero, i_clk, i_rst_n, out_short, r_out_value == '0 && r_out_index == '0)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the row k-th smallest select unit with a selection predictor

module testbench import rkss_pkg::*; ();

    localparam int ROW_CAP     = 4096;
    localparam int KEEP_MAX    = 64;
    localparam int ROW_LATENCY = KEEP_MAX + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_ROWS   = 3;
    localparam int PHASE_ITEMS = 24;
    localparam int NUM_PHASES  = 12;
    localparam int MAX_REPORTS = 100;

    localparam int PHASE_RANK [NUM_PHASES] = '{1, 64, 5, 0, 127, 2, 33, 64, 100, 1, 17, 3};
    localparam int PHASE_FMT  [NUM_PHASES] = '{0, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1};

    typedef enum logic {DO_ELEM, DO_CFG} t_step_kind;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [IDX_W-1:0]    index;
        logic [STATUS_W-1:0] status;
    } t_kth_result;

    typedef struct packed {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic [VAL_W-1:0]      value;
        logic                  last;
        logic                  typed;
        t_kth_result           result;
    } t_stim_step;

    t_stim_step directed_steps [25] = '{
        '{DO_ELEM, '0, '0, 64'd5, 1'b1, 1'b1, '{64'd5, 12'd0, ST_OK}},
        '{DO_ELEM, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h8000_0000_0000_0000, 1'b1, 1'b1,
          '{64'h8000_0000_0000_0000, 12'd1, ST_OK}},
        '{DO_CFG, CFG_K_RANK, 7'd3, '0, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd2, 1'b1, 1'b1, '{64'd0, 12'd0, ST_SHORT}},
        '{DO_ELEM, '0, '0, 64'd7, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd7, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd7, 1'b1, 1'b1, '{64'd7, 12'd2, ST_OK}},
        '{DO_CFG, CFG_K_RANK, 7'd0, '0, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd1, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 12'd1, ST_OK}},
        '{DO_CFG, CFG_K_RANK, 7'd127, '0, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd0, 1'b1, 1'b1, '{64'd0, 12'd0, ST_SHORT}},
        '{DO_CFG, CFG_K_RANK, 7'd1, '0, 1'b0, 1'b0, '0},
        '{DO_CFG, CFG_VALUE_FORMAT, 7'd1, '0, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h7FF8_0000_0000_0000, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h7FF0_0000_0000_0000, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'd0, 1'b1, 1'b1, '{64'h8000_0000_0000_0000, 12'd2, ST_OK}},
        '{DO_CFG, CFG_K_RANK, 7'd3, '0, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'hFFF0_0000_0000_0001, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h7FF0_0000_0000_0001, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'hFFF0_0000_0000_0000, 1'b0, 1'b0, '0},
        '{DO_ELEM, '0, '0, 64'h3FF0_0000_0000_0000, 1'b1, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rkss_in_if  elem_if ();
    rkss_out_if res_if ();

    row_kth_smallest_select_unit #(.ROW_MAX(ROW_CAP), .K_MAX(KEEP_MAX)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_elem     (elem_if),
        .o_result   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [VAL_W-1:0] kept_vals [KEEP_MAX];
    logic [IDX_W-1:0] kept_pos [KEEP_MAX];
    int               kept_count = 0;
    logic [12:0]      row_pos = '0;
    logic [K_W-1:0]   rank_reg = 7'd1;
    logic             format_reg = 1'b0;

    t_kth_result pending_kth [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          hold_request = 1'b0;

    function automatic logic [VAL_W-1:0] rank_key(input logic [VAL_W-1:0] v,
                                                  input logic as_double);
        if (!as_double) return {~v[63], v[62:0]};
        if (v[62:52] == 11'h7FF && v[51:0] != 52'd0) return {VAL_W{1'b1}};
        if (v[62:0] == 63'd0) return {1'b1, 63'd0};
        return v[63] ? ~v : {1'b1, v[62:0]};
    endfunction

    task automatic predict_kth(input logic [VAL_W-1:0] v, input logic last,
                               output bit has_res, output t_kth_result res);
        logic [VAL_W-1:0] key;
        logic             over;
        logic [IDX_W-1:0] pos;
        int               slot;
        int               top;
        int               k;
        key  = rank_key(v, format_reg);
        over = row_pos >= ROW_CAP;
        pos  = over ? IDX_W'(ROW_CAP - 1) : row_pos[IDX_W-1:0];
        slot = 0;
        while (slot < kept_count && rank_key(kept_vals[slot], format_reg) <= key) slot++;
        if (slot < KEEP_MAX) begin
            top = (kept_count < KEEP_MAX) ? kept_count : KEEP_MAX - 1;
            for (int i = top; i > slot; i--) begin
                kept_vals[i] = kept_vals[i-1];
                kept_pos[i]  = kept_pos[i-1];
            end
            kept_vals[slot] = v;
            kept_pos[slot]  = pos;
            if (kept_count < KEEP_MAX) kept_count++;
        end
        if (!over) row_pos++;
        has_res = last;
        res     = '0;
        if (last) begin
            k = (rank_reg == 0) ? 1 : ((rank_reg > KEEP_MAX) ? KEEP_MAX : int'(rank_reg));
            if (kept_count < k) begin
                res.status = ST_SHORT;
            end else begin
                res.value  = kept_vals[k-1];
                res.index  = kept_pos[k-1];
                res.status = over ? ST_LONG : ST_OK;
            end
            row_pos    = '0;
            kept_count = 0;
        end
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [VAL_W-1:0] rand_elem(input logic as_double);
        logic [VAL_W-1:0] raw;
        int               r;
        raw = {$urandom, $urandom};
        r   = $urandom_range(0, 9);
        if (r < 4) return raw;
        if (!as_double) begin
            if (r < 6) return {{60{raw[3]}}, raw[3:0]};
            if (r == 6) begin
                unique case (raw[1:0])
                    2'd0:    return 64'h7FFF_FFFF_FFFF_FFFF;
                    2'd1:    return 64'h8000_0000_0000_0000;
                    2'd2:    return 64'd0;
                    default: return 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            return {{40{raw[63]}}, raw[23:0]};
        end
        if (r < 6) begin
            unique case (raw[2:0])
                3'd0:    return 64'h0000_0000_0000_0000;
                3'd1:    return 64'h8000_0000_0000_0000;
                3'd2:    return 64'h7FF0_0000_0000_0000;
                3'd3:    return 64'hFFF0_0000_0000_0000;
                3'd4:    return 64'h3FF0_0000_0000_0000;
                3'd5:    return 64'hBFF0_0000_0000_0000;
                3'd6:    return 64'h7FF8_0000_0000_0000;
                default: return 64'h0000_0000_0000_0001;
            endcase
        end
        // nan with random sign and payload
        if (r == 6) return {raw[63], 11'h7FF, raw[51:1], 1'b1};
        return {raw[63], (raw[62:52] == 11'h7FF) ? 11'h7FE : raw[62:52], raw[51:0]};
    endfunction

    function automatic int pick_row_len(input int k_eff);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return (k_eff > 1) ? $urandom_range(1, k_eff - 1) : 1;
        if (r < 8) return $urandom_range(k_eff, k_eff + 6);
        return $urandom_range(1, 2 * k_eff + 20);
    endfunction

    task automatic send_elem(input logic [VAL_W-1:0] v, input logic last, input int gap,
                             input bit typed, input t_kth_result typed_res);
        bit          has_res;
        t_kth_result res;
        if (gap > 0) begin
            elem_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_if.valid       <= 1'b1;
        elem_if.elem_value  <= v;
        elem_if.last_in_row <= last;
        @(posedge i_clk);
        while (!elem_if.ready) @(posedge i_clk);
        predict_kth(v, last, has_res, res);
        if (has_res) pending_kth.push_back(typed ? typed_res : res);
    endtask

    task automatic send_row(input int len, input logic as_double, input bit steady);
        for (int n = 0; n < len; n++) begin
            send_elem(rand_elem(as_double), n == len - 1, pick_gap(steady), 1'b0, '0);
        end
    endtask

    // drop valid and wait until the pipeline is empty
    task automatic settle_idle();
        elem_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_kth.size() != 0) @(posedge i_clk);
        repeat (ROW_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_K_RANK) rank_reg = data;
        else format_reg = data[0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string field, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic check_kth(input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] index,
                             input logic [STATUS_W-1:0] status);
        t_kth_result want;
        if (pending_kth.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected result transaction: value %h index %0d status %0d",
                         $time, value, index, status);
            return;
        end
        want = pending_kth.pop_front();
        if (value !== want.value) note_mismatch("kth_value", want.value, value);
        if (index !== want.index) note_mismatch("kth_index", VAL_W'(want.index), VAL_W'(index));
        if (status !== want.status)
            note_mismatch("status", VAL_W'(want.status), VAL_W'(status));
    endtask

    // result side: random back-pressure plus one long hold on request
    initial begin
        int stall_left;
        bit rx_steady;
        stall_left = 0;
        rx_steady  = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                check_kth(res_if.kth_value, res_if.kth_index, res_if.status);
            if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap(1'b0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int k_eff;
        int sent;
        int len;
        bit steady;
        bit paused;
        paused = 1'b0;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_wdata         <= '0;
        elem_if.valid       <= 1'b0;
        elem_if.elem_value  <= '0;
        elem_if.last_in_row <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[s]) begin
            if (directed_steps[s].kind == DO_CFG) begin
                settle_idle();
                cfg_write(directed_steps[s].cfg_index, directed_steps[s].cfg_data);
            end else begin
                send_elem(directed_steps[s].value, directed_steps[s].last, pick_gap(1'b0),
                          directed_steps[s].typed, directed_steps[s].result);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            cfg_write(CFG_K_RANK, CFG_DATA_W'(PHASE_RANK[ph]));
            cfg_write(CFG_VALUE_FORMAT, CFG_DATA_W'(PHASE_FMT[ph]));
            k_eff = (PHASE_RANK[ph] == 0) ? 1 :
                    ((PHASE_RANK[ph] > KEEP_MAX) ? KEEP_MAX : PHASE_RANK[ph]);
            // fill the chain while the result side holds off
            if (ph == 1) hold_request = 1'b1;
            sent = 0;
            while (sent < ((ph == 1) ? HOLD_ROWS * k_eff : PHASE_ITEMS)) begin
                if (ph == 4 && !paused && sent >= PHASE_ITEMS / 2) begin
                    settle_idle();
                    paused = 1'b1;
                end
                steady = (ph == 1) || ($urandom_range(0, 4) == 0);
                len    = (ph == 1) ? k_eff : pick_row_len(k_eff);
                send_row(len, PHASE_FMT[ph] != 0, steady);
                sent += len;
            end
        end

        settle_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
